// ===== src/assert_macros.svh =====
// assertion macros shared by the rtl files
// no dependencies; clocked on clk, disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge of clk
`define CHK_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked at every rising edge of clk
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/cscs_pkg.sv =====
// types, codes and sizes for the call-site cluster scoring table
// no dependencies
`timescale 1ns / 1ps

package cscs_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = 6;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    REQ_RESET  = 2'd0,
    REQ_BEGIN  = 2'd1,
    REQ_SAMPLE = 2'd2
  } req_code_t;

  localparam logic [2:0] CFG_MOVE_W   = 3'd0;
  localparam logic [2:0] CFG_LOCAL_W  = 3'd1;
  localparam logic [2:0] CFG_EXCESS_W = 3'd2;
  localparam logic [2:0] CFG_SYN_PEN  = 3'd3;
  localparam logic [2:0] CFG_PROM_THR = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] site_addr;
    logic        is_synthetic;
    logic        local_valid;
    logic        moving;
  } item_t;

  typedef struct packed {
    logic [31:0]      session_num;
    logic             is_active;
    logic [31:0]      total_samples;
    logic [31:0]      accepted_samples;
    logic [31:0]      synthetic_samples;
    logic [CNT_W-1:0] used_entries;
    logic [CNT_W-1:0] promoted_entries;
    logic             recorded;
    logic [4:0]       hit_entry;
    logic [31:0]      hit_samples;
    logic [31:0]      hit_score;
    logic             hit_promoted;
  } result_t;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] samples;
    logic [31:0] synth;
    logic [31:0] moves;
    logic [31:0] idles;
    logic [31:0] locals;
  } entry_t;

  typedef struct packed {
    logic             clr;
    logic             we;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic [IDX_W-1:0] rd_addr;
  } ram_ctl_t;

endpackage

// ===== src/callsite_cluster_scoring_table.sv =====
// top level of the call-site cluster scoring table: sequencer, counters, shared multiplier
// depends on cscs_pkg, cscs_entry_ram and assert_macros.svh
`timescale 1ns / 1ps
//
// usage
//   request channel: drive item and raise start; the request is taken at a rising
//   edge where start is high and busy is low. busy stays high until the result.
//   result channel: done is high for exactly one cycle with result valid; the
//   receiver cannot stall, so the result must be captured in that cycle.
//   config port: cfg_we writes cfg_data into register cfg_index at the edge;
//   write only while busy is low and no result is pending.
// sequence
//   reset/begin/ignored requests: go straight to the finish state, which loads the result.
//   sample requests: a lookup sweep (read, compare) per entry scanned (up to 32),
//   a load of the hit entry (read, load), an update of it, then a scoring sweep:
//   read and load for every entry, plus four multiply steps per occupied entry
//   through the single shared 32x8 multiplier, then the finish state loads the
//   result and raises done.
// reset
//   rst restores the register defaults, clears all entries (valid bits) and
//   counters, sets the next session to 1. a reset request clears the same state
//   but keeps the registers. no clearing pass is needed.

module callsite_cluster_scoring_table (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  cscs_pkg::item_t   item,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output logic              done,
  output cscs_pkg::result_t result
);

  `include "assert_macros.svh"

  typedef enum logic [13:0] {
    ST_IDLE     = 14'b00000000000001,
    ST_SCAN_RD  = 14'b00000000000010,
    ST_SCAN_CMP = 14'b00000000000100,
    ST_LOAD_RD  = 14'b00000000001000,
    ST_LOAD     = 14'b00000000010000,
    ST_UPDATE   = 14'b00000000100000,
    ST_SC_RD    = 14'b00000001000000,
    ST_SC_LD    = 14'b00000010000000,
    ST_MUL0     = 14'b00000100000000,
    ST_MUL1     = 14'b00001000000000,
    ST_MUL2     = 14'b00010000000000,
    ST_MUL3     = 14'b00100000000000,
    ST_FINISH   = 14'b01000000000000,
    ST_HOLD     = 14'b10000000000000
  } state_t;

  state_t state;

  // configuration registers
  logic [7:0]  move_w, local_w, excess_w, syn_pen;
  logic [15:0] prom_thr;

  // session state and global counters
  logic [31:0] next_session, cur_session;
  logic        active;
  logic [31:0] sample_total, accepted_total, synthetic_total;
  logic [cscs_pkg::CNT_W-1:0] alloc_count, promote_count, prom;

  // per-request working registers
  cscs_pkg::item_t                req;
  logic [cscs_pkg::IDX_W-1:0]     k, hit, free_idx;
  logic                           found, have_free, rec;
  cscs_pkg::entry_t               w, sc;
  logic [31:0]                    acc, hscore;
  logic                           hflag;

  cscs_pkg::ram_ctl_t ram_ctl;
  cscs_pkg::entry_t   rd_data;

  cscs_entry_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ram_ctl),
    .rd_data (rd_data)
  );

  // shared multiplier, product kept modulo 2^32
  logic [31:0] mul_a;
  logic [7:0]  mul_b;
  logic [39:0] prod_full;
  logic [31:0] prod;

  always_comb begin
    mul_a = sc.moves;
    mul_b = move_w;
    unique case (state)
      ST_MUL1: begin
        mul_a = sc.locals;
        mul_b = local_w;
      end
      ST_MUL2: begin
        mul_a = sc.moves - sc.idles;
        mul_b = excess_w;
      end
      ST_MUL3: begin
        mul_a = sc.synth;
        mul_b = syn_pen;
      end
      default: begin
        mul_a = sc.moves;
        mul_b = move_w;
      end
    endcase
  end

  assign prod_full = {8'd0, mul_a} * {32'd0, mul_b};
  assign prod      = prod_full[31:0];

  // final score step: penalty floored at zero, then promotion test
  logic [31:0] s_fin;
  logic        flag_fin;

  always_comb begin
    s_fin = acc;
    if (sc.synth != 32'd0) begin
      s_fin = (prod > acc) ? 32'd0 : (acc - prod);
    end
    flag_fin = (sc.key != 64'd0) && (s_fin >= {16'd0, prom_thr}) && (sc.synth == 32'd0);
  end

  // updated hit entry
  cscs_pkg::entry_t w_next;

  always_comb begin
    w_next         = w;
    w_next.samples = w.samples + 32'd1;
    if (req.is_synthetic) begin
      w_next.synth = w.synth + 32'd1;
    end
    if (req.moving) begin
      w_next.moves = w.moves + 32'd1;
    end else begin
      w_next.idles = w.idles + 32'd1;
    end
    if (req.local_valid) begin
      w_next.locals = w.locals + 32'd1;
    end
  end

  logic clr_req;

  always_comb begin
    ram_ctl.clr     = clr_req;
    ram_ctl.we      = (state == ST_UPDATE);
    ram_ctl.wr_addr = hit;
    ram_ctl.wr_data = w_next;
    ram_ctl.rd_addr = (state == ST_LOAD_RD) ? hit : k;
  end

  assign clr_req = (state == ST_IDLE) && start &&
                   ((item.req_type == cscs_pkg::REQ_RESET) ||
                    (item.req_type == cscs_pkg::REQ_BEGIN));

  assign busy = (state != ST_IDLE);

  logic last_k;
  assign last_k = (k == cscs_pkg::LAST_IDX);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      move_w   <= 8'd10;
      local_w  <= 8'd5;
      excess_w <= 8'd4;
      syn_pen  <= 8'd8;
      prom_thr <= 16'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cscs_pkg::CFG_MOVE_W:   move_w   <= cfg_data[7:0];
        cscs_pkg::CFG_LOCAL_W:  local_w  <= cfg_data[7:0];
        cscs_pkg::CFG_EXCESS_W: excess_w <= cfg_data[7:0];
        cscs_pkg::CFG_SYN_PEN:  syn_pen  <= cfg_data[7:0];
        cscs_pkg::CFG_PROM_THR: prom_thr <= cfg_data;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        req <= item;
      end
      ST_LOAD: begin
        if (!found && have_free) begin
          // fresh entry: key set, all counters zero
          w <= '{key: req.site_addr, default: 32'd0};
        end else begin
          w <= rd_data;
        end
      end
      ST_UPDATE: begin
        w <= w_next;
      end
      ST_SC_LD: begin
        sc <= rd_data;
      end
      ST_MUL0: begin
        acc <= prod;
      end
      ST_MUL1: begin
        acc <= acc + prod;
      end
      ST_MUL2: begin
        if (sc.idles < sc.moves) begin
          acc <= acc + prod;
        end
      end
      default: ;
    endcase
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      done            <= 1'b0;
      next_session    <= 32'd1;
      cur_session     <= 32'd0;
      active          <= 1'b0;
      sample_total    <= 32'd0;
      accepted_total  <= 32'd0;
      synthetic_total <= 32'd0;
      alloc_count     <= '0;
      promote_count   <= '0;
      rec             <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            rec       <= 1'b0;
            k         <= '0;
            found     <= 1'b0;
            have_free <= 1'b0;
            free_idx  <= '0;
            hscore    <= 32'd0;
            hflag     <= 1'b0;
            prom      <= '0;
            state     <= ST_FINISH;
            if (item.req_type == cscs_pkg::REQ_RESET) begin
              next_session    <= 32'd1;
              cur_session     <= 32'd0;
              active          <= 1'b0;
              sample_total    <= 32'd0;
              accepted_total  <= 32'd0;
              synthetic_total <= 32'd0;
              alloc_count     <= '0;
              promote_count   <= '0;
            end else if (item.req_type == cscs_pkg::REQ_BEGIN) begin
              // a wrapped session number skips zero
              if (next_session == 32'd0) begin
                cur_session  <= 32'd1;
                next_session <= 32'd2;
              end else begin
                cur_session  <= next_session;
                next_session <= next_session + 32'd1;
              end
              active          <= 1'b1;
              sample_total    <= 32'd0;
              accepted_total  <= 32'd0;
              synthetic_total <= 32'd0;
              alloc_count     <= '0;
              promote_count   <= '0;
            end else if (item.req_type == cscs_pkg::REQ_SAMPLE && active) begin
              state <= ST_SCAN_RD;
            end
          end
        end
        ST_SCAN_RD: begin
          state <= ST_SCAN_CMP;
        end
        ST_SCAN_CMP: begin
          if (rd_data.samples != 32'd0 && rd_data.key == req.site_addr) begin
            hit   <= k;
            found <= 1'b1;
            state <= ST_LOAD_RD;
          end else begin
            if (rd_data.samples == 32'd0 && !have_free) begin
              have_free <= 1'b1;
              free_idx  <= k;
            end
            if (last_k) begin
              // miss: first free entry, else fold into the last entry
              if (have_free) begin
                hit <= free_idx;
              end else if (rd_data.samples == 32'd0) begin
                hit <= k;
              end else begin
                hit <= cscs_pkg::LAST_IDX;
              end
              state <= ST_LOAD_RD;
            end else begin
              k     <= k + 1'b1;
              state <= ST_SCAN_RD;
            end
          end
        end
        ST_LOAD_RD: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (!found && have_free) begin
            alloc_count <= alloc_count + 1'b1;
          end
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          sample_total <= sample_total + 32'd1;
          if (req.is_synthetic) begin
            synthetic_total <= synthetic_total + 32'd1;
          end else begin
            accepted_total <= accepted_total + 32'd1;
          end
          rec   <= 1'b1;
          k     <= '0;
          state <= ST_SC_RD;
        end
        ST_SC_RD: begin
          state <= ST_SC_LD;
        end
        ST_SC_LD: begin
          if (rd_data.samples == 32'd0) begin
            if (last_k) begin
              promote_count <= prom;
              state         <= ST_FINISH;
            end else begin
              k     <= k + 1'b1;
              state <= ST_SC_RD;
            end
          end else begin
            state <= ST_MUL0;
          end
        end
        ST_MUL0: begin
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          state <= ST_MUL3;
        end
        ST_MUL3: begin
          if (k == hit) begin
            hscore <= s_fin;
            hflag  <= flag_fin;
          end
          if (last_k) begin
            promote_count <= prom + {{(cscs_pkg::CNT_W-1){1'b0}}, flag_fin};
            state         <= ST_FINISH;
          end else begin
            prom  <= prom + {{(cscs_pkg::CNT_W-1){1'b0}}, flag_fin};
            k     <= k + 1'b1;
            state <= ST_SC_RD;
          end
        end
        ST_FINISH: begin
          done  <= 1'b1;
          state <= ST_HOLD;
        end
        ST_HOLD: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result register, loaded as the sequencer finishes
  always_ff @(posedge clk) begin
    if (state == ST_FINISH) begin
      result.session_num       <= cur_session;
      result.is_active         <= active;
      result.total_samples     <= sample_total;
      result.accepted_samples  <= accepted_total;
      result.synthetic_samples <= synthetic_total;
      result.used_entries      <= alloc_count;
      result.promoted_entries  <= promote_count;
      result.recorded          <= rec;
      result.hit_entry         <= rec ? 5'(hit) : 5'd0;
      result.hit_samples       <= rec ? w.samples : 32'd0;
      result.hit_score         <= rec ? hscore : 32'd0;
      result.hit_promoted      <= rec ? hflag : 1'b0;
    end
  end

  `CHK_NEXT(a_finish_done, state == ST_FINISH, done)
  `CHK_NEXT(a_accept_busy, start && !busy, busy)
  `CHK_IMPL(a_rec_active, done && result.recorded, result.is_active)
  `CHK_IMPL(a_prom_bound, 1'b1, promote_count <= cscs_pkg::CNT_W'(cscs_pkg::ENTRIES))

endmodule

// ===== src/cscs_entry_ram.sv =====
// entry store: one write port, one registered read port, per-entry valid bits
// depends on cscs_pkg
`timescale 1ns / 1ps

module cscs_entry_ram (
  input  logic               clk,
  input  logic               rst,
  input  cscs_pkg::ram_ctl_t ctl,
  output cscs_pkg::entry_t   rd_data
);

  cscs_pkg::entry_t                 mem [cscs_pkg::ENTRIES];
  logic [cscs_pkg::ENTRIES-1:0]     valid;
  cscs_pkg::entry_t                 rd_q;
  logic                             rd_vld;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    rd_q <= mem[ctl.rd_addr];
  end

  // invalid entries read back as all zero
  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (ctl.we) begin
        valid[ctl.wr_addr] <= 1'b1;
      end
      rd_vld <= valid[ctl.rd_addr];
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

// ===== sim/cscs_checker.sv =====
// checker for the call-site cluster scoring table: watches requests, config writes and results
// depends on cscs_pkg; keeps its own copy of the table and compares every result
`timescale 1ns / 1ps

module cscs_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  cscs_pkg::item_t   item,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              done,
  input  cscs_pkg::result_t result,
  output int                fail_count,
  output int                pending_count
);
  import cscs_pkg::*;

  logic [7:0]  w_move, w_local, w_excess, w_pen;
  logic [15:0] thr;

  logic [63:0] key_q [ENTRIES];
  logic [31:0] samp_q [ENTRIES];
  logic [31:0] syn_q [ENTRIES];
  logic [31:0] mov_q [ENTRIES];
  logic [31:0] idl_q [ENTRIES];
  logic [31:0] loc_q [ENTRIES];
  logic        flag_q [ENTRIES];
  logic [31:0] next_sess, cur_sess, tot, acc, syn;
  logic        active;
  logic [5:0]  used, prom;

  result_t expected_results[$];

  assign pending_count = expected_results.size();

  function automatic logic [31:0] entry_score(int k);
    logic [31:0] s, pen;
    s = mov_q[k] * w_move + loc_q[k] * w_local;
    if (idl_q[k] < mov_q[k]) s += (mov_q[k] - idl_q[k]) * w_excess;
    if (syn_q[k] != 0) begin
      pen = syn_q[k] * w_pen;
      s = (pen > s) ? 32'd0 : s - pen;
    end
    return s;
  endfunction

  task automatic clear_table();
    for (int k = 0; k < ENTRIES; k++) begin
      key_q[k] = '0; samp_q[k] = '0; syn_q[k] = '0;
      mov_q[k] = '0; idl_q[k] = '0; loc_q[k] = '0; flag_q[k] = 1'b0;
    end
    tot = '0; acc = '0; syn = '0; used = '0; prom = '0;
  endtask

  task automatic clear_all();
    clear_table();
    next_sess = 32'd1; cur_sess = '0; active = 1'b0;
  endtask

  // applies one request to the table copy and queues the result it yields
  task automatic predict_request(item_t it);
    result_t r;
    int hit, free_idx, n;
    bit found, have_free;
    logic [31:0] s, hscore;
    r = '0; hit = 0; hscore = '0;
    if (it.req_type == REQ_RESET) begin
      clear_all();
    end else if (it.req_type == REQ_BEGIN) begin
      if (next_sess == 0) next_sess = 32'd1;
      cur_sess = next_sess;
      next_sess = next_sess + 1;
      active = 1'b1;
      clear_table();
    end else if (it.req_type == REQ_SAMPLE && active) begin
      found = 0; have_free = 0; free_idx = 0; n = 0;
      for (int k = 0; k < ENTRIES; k++) begin
        if (samp_q[k] == 0) begin
          if (!have_free) begin
            have_free = 1; free_idx = k;
          end
        end else if (key_q[k] == it.site_addr) begin
          hit = k; found = 1; break;
        end
      end
      if (!found) begin
        if (have_free) begin
          hit = free_idx;
          key_q[hit] = it.site_addr; samp_q[hit] = '0; syn_q[hit] = '0;
          mov_q[hit] = '0; idl_q[hit] = '0; loc_q[hit] = '0; flag_q[hit] = 1'b0;
          used = used + 1;
        end else begin
          hit = ENTRIES - 1;
        end
      end
      tot++;
      if (it.is_synthetic) begin
        syn++; syn_q[hit]++;
      end else begin
        acc++;
      end
      samp_q[hit]++;
      if (it.moving) mov_q[hit]++;
      else idl_q[hit]++;
      if (it.local_valid) loc_q[hit]++;
      for (int k = 0; k < ENTRIES; k++) begin
        if (samp_q[k] == 0) continue;
        s = entry_score(k);
        flag_q[k] = key_q[k] != 0 && s >= {16'd0, thr} && syn_q[k] == 0;
        if (flag_q[k]) n++;
        if (k == hit) hscore = s;
      end
      prom = n[5:0];
      r.recorded = 1'b1;
      r.hit_entry = hit[4:0];
      r.hit_samples = samp_q[hit];
      r.hit_score = samp_q[hit] != 0 ? hscore : '0;
      r.hit_promoted = samp_q[hit] != 0 ? flag_q[hit] : 1'b0;
    end
    r.session_num = cur_sess;
    r.is_active = active;
    r.total_samples = tot;
    r.accepted_samples = acc;
    r.synthetic_samples = syn;
    r.used_entries = used;
    r.promoted_entries = prom;
    expected_results.push_back(r);
  endtask

  task automatic compare_result(result_t got);
    result_t exp;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      fail_count++;
      return;
    end
    exp = expected_results.pop_front();
    if (got !== exp) begin
      $display("%0t: result mismatch expected %h actual %h", $time, exp, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      w_move <= 8'd10; w_local <= 8'd5; w_excess <= 8'd4; w_pen <= 8'd8; thr <= 16'd10;
      clear_all();
      expected_results.delete();
    end else begin
      if (done) compare_result(result);
      if (cfg_we) begin
        case (cfg_index)
          CFG_MOVE_W:   w_move <= cfg_data[7:0];
          CFG_LOCAL_W:  w_local <= cfg_data[7:0];
          CFG_EXCESS_W: w_excess <= cfg_data[7:0];
          CFG_SYN_PEN:  w_pen <= cfg_data[7:0];
          CFG_PROM_THR: thr <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) predict_request(item);
    end
  end

  initial fail_count = 0;
endmodule

// ===== sim/tb_top.sv =====
// stimulus and verdict for the call-site cluster scoring table
// depends on cscs_pkg, the block and cscs_checker
`timescale 1ns / 1ps

module tb_top;
  import cscs_pkg::*;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  item_t   item = '0;
  logic    cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic    done;
  result_t result;
  int      fail_count, pending_count;
  int      cycle_count = 0;

  // small pool of addresses so that samples hit existing entries often
  logic [63:0] addr_pool [40];

  callsite_cluster_scoring_table dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .result(result)
  );

  cscs_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .result(result),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // generous watchdog covering ~900 requests plus gaps
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1500000) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // send one request; start stays high until the edge that takes it,
  // then drops for one cycle while the block is busy anyway
  task automatic send_request(logic [1:0] rt, logic [63:0] a, logic s, logic l, logic m);
    item_t it;
    it.req_type = rt; it.site_addr = a;
    it.is_synthetic = s; it.local_valid = l; it.moving = m;
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_sample(int pool_size);
    send_request(REQ_SAMPLE, addr_pool[$urandom_range(pool_size - 1)],
                 $urandom_range(9) == 0, $urandom_range(1), $urandom_range(1));
  endtask

  // quiet point: all results in, then an idle wait
  task automatic drain();
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_weights(logic [7:0] mw, logic [7:0] lw, logic [7:0] ew,
                             logic [7:0] pw, logic [15:0] th);
    drain();
    write_reg(CFG_MOVE_W, {8'd0, mw});
    write_reg(CFG_LOCAL_W, {8'd0, lw});
    write_reg(CFG_EXCESS_W, {8'd0, ew});
    write_reg(CFG_SYN_PEN, {8'd0, pw});
    write_reg(CFG_PROM_THR, th);
  endtask

  // bursty random phase; mostly sessions full of samples, some noise
  task automatic random_phase(int n, int pool_size);
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        repeat ($urandom_range(6)) @(posedge clk);
        burst = $urandom_range(1, 12);
      end
      burst--;
      case ($urandom_range(99))
        0:       send_request(REQ_RESET, {$urandom, $urandom}, $urandom, $urandom, $urandom);
        1, 2:    send_request(REQ_BEGIN, {$urandom, $urandom}, $urandom, $urandom, $urandom);
        3:       send_request(2'd3, {$urandom, $urandom}, $urandom, $urandom, $urandom);
        4:       send_request(REQ_SAMPLE, {$urandom, $urandom}, $urandom, $urandom, $urandom);
        default: random_sample(pool_size);
      endcase
    end
  endtask

  initial begin
    for (int k = 0; k < 40; k++) addr_pool[k] = {$urandom, $urandom};
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: sample while inactive, unknown code, session, extremes of address
    send_request(REQ_SAMPLE, 64'h1234, 1'b0, 1'b1, 1'b1);
    send_request(2'd3, '1, 1'b1, 1'b1, 1'b1);
    send_request(REQ_BEGIN, '0, 1'b0, 1'b0, 1'b0);
    send_request(REQ_SAMPLE, '0, 1'b0, 1'b1, 1'b1);
    send_request(REQ_SAMPLE, '1, 1'b0, 1'b1, 1'b1);
    send_request(REQ_SAMPLE, '1, 1'b0, 1'b0, 1'b0);
    send_request(REQ_SAMPLE, 64'hA5A5_5A5A_0F0F_F0F0, 1'b1, 1'b1, 1'b1);
    send_request(REQ_SAMPLE, 64'h5A5A_A5A5_F0F0_0F0F, 1'b0, 1'b0, 1'b1);
    // overfill the table so misses land in the last entry
    for (int k = 0; k < 34; k++) send_request(REQ_SAMPLE, 64'h100 + k, 1'b0, 1'b1, 1'b1);
    send_request(REQ_RESET, '0, 1'b0, 1'b0, 1'b0);
    send_request(REQ_SAMPLE, 64'h55, 1'b0, 1'b0, 1'b0);
    send_request(REQ_BEGIN, '1, 1'b1, 1'b1, 1'b1);

    random_phase(200, 40);
    // hold off until the block has caught up
    drain();
    send_request(REQ_BEGIN, '0, 1'b0, 1'b0, 1'b0);
    set_weights(8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF);
    random_phase(200, 8);
    set_weights(8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
    random_phase(150, 40);
    set_weights(8'd200, 8'd1, 8'd0, 8'd255, 16'd300);
    random_phase(150, 20);
    set_weights($urandom, $urandom, $urandom, $urandom, $urandom_range(2000));
    random_phase(150, 12);

    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end
endmodule
